@@ rtl/lca_pkg.sv @@
`timescale 1ns / 1ps

package lca_pkg;

    localparam int DIR_W   = 16;
    localparam int POS_W   = 20;
    localparam int DIST_W  = 21;
    localparam int LIMIT_W = 29;

    localparam int DIR_FRAC_BITS = 14;
    localparam int DOT_FRAC      = 28;
    localparam int PROJ_DROP     = 8;
    localparam int DEN_SHIFT     = DOT_FRAC + PROJ_DROP - DIR_FRAC_BITS;

    // divider: magnitude of numerator, divisor and quotient
    localparam int DIV_N_W   = 58;
    localparam int DIV_D_W   = 35;
    localparam int DIV_Q_W   = 41;
    localparam int DIV_CMP_W = DIV_D_W + DIV_Q_W;

    // square root: radicand and root
    localparam int SQ_IN_W  = 44;
    localparam int SQ_OUT_W = SQ_IN_W / 2;
    localparam int SQ_REM_W = SQ_OUT_W + 2;

    localparam int STEP_W = DIV_Q_W + 1;

    typedef struct packed {
        logic [2:0][DIR_W-1:0] ua;
        logic [2:0][DIR_W-1:0] ub;
        logic [2:0][POS_W-1:0] pa;
        logic [2:0][POS_W-1:0] pb;
    } geom_t;

    typedef struct packed {
        logic neg;
        logic nneg;
        logic nzero;
        logic dzero;
        logic ovf;
    } div_flag_t;

    typedef struct packed {
        geom_t     g;
        logic      par;
        div_flag_t f1;
        div_flag_t f2;
    } div_side_t;

    typedef struct packed {
        logic [2:0][POS_W-1:0] na;
        logic [2:0][POS_W-1:0] nb;
        logic                  par;
        logic                  pos;
    } sq_side_t;

endpackage

@@ rtl/lca_div.sv @@
`timescale 1ns / 1ps

// restoring divider, one quotient bit per stage
module lca_div (
    input  logic                        aclk,
    input  logic                        en,
    input  logic [lca_pkg::DIV_N_W-1:0] num_mag,
    input  logic [lca_pkg::DIV_D_W-1:0] den_mag,
    output logic [lca_pkg::DIV_Q_W-1:0] quo
);
    import lca_pkg::*;

    logic [DIV_N_W-1:0] rem_reg [DIV_Q_W];
    logic [DIV_N_W-1:0] rem_next [DIV_Q_W];
    logic [DIV_Q_W-1:0] quo_reg [DIV_Q_W];
    logic [DIV_Q_W-1:0] quo_next [DIV_Q_W];
    logic [DIV_D_W-1:0] den_reg [DIV_Q_W];
    logic [DIV_N_W-1:0] rem_in [DIV_Q_W];
    logic [DIV_Q_W-1:0] quo_in [DIV_Q_W];
    logic [DIV_D_W-1:0] den_in [DIV_Q_W];

    for (genvar s = 0; s < DIV_Q_W; s++) begin : g_stage
        localparam int J = DIV_Q_W - 1 - s;
        logic [DIV_CMP_W-1:0] shifted;
        logic                 ge;

        if (s == 0) begin : g_first
            assign rem_in[s] = num_mag;
            assign quo_in[s] = '0;
            assign den_in[s] = den_mag;
        end else begin : g_rest
            assign rem_in[s] = rem_reg[s-1];
            assign quo_in[s] = quo_reg[s-1];
            assign den_in[s] = den_reg[s-1];
        end

        assign shifted     = DIV_CMP_W'(den_in[s]) << J;
        assign ge          = DIV_CMP_W'(rem_in[s]) >= shifted;
        assign rem_next[s] = ge ? rem_in[s] - shifted[DIV_N_W-1:0] : rem_in[s];
        assign quo_next[s] = {quo_in[s][DIV_Q_W-2:0], ge};

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[s] <= rem_next[s];
                quo_reg[s] <= quo_next[s];
                den_reg[s] <= den_in[s];
            end
        end
    end

    assign quo = quo_reg[DIV_Q_W-1];

endmodule

@@ rtl/lca_sqrt.sv @@
`timescale 1ns / 1ps

// digit-by-digit integer square root, one root bit per stage
module lca_sqrt (
    input  logic                         aclk,
    input  logic                         en,
    input  logic [lca_pkg::SQ_IN_W-1:0]  radicand,
    output logic [lca_pkg::SQ_OUT_W-1:0] root
);
    import lca_pkg::*;

    logic [SQ_IN_W-1:0]  x_reg [SQ_OUT_W];
    logic [SQ_REM_W-1:0] rem_reg [SQ_OUT_W];
    logic [SQ_OUT_W-1:0] root_reg [SQ_OUT_W];
    logic [SQ_IN_W-1:0]  x_in [SQ_OUT_W];
    logic [SQ_REM_W-1:0] rem_in [SQ_OUT_W];
    logic [SQ_OUT_W-1:0] root_in [SQ_OUT_W];

    for (genvar s = 0; s < SQ_OUT_W; s++) begin : g_stage
        logic [SQ_REM_W-1:0] rem_sh;
        logic [SQ_REM_W-1:0] trial;
        logic                ge;
        logic [SQ_IN_W-1:0]  x_next;
        logic [SQ_REM_W-1:0] rem_next;
        logic [SQ_OUT_W-1:0] root_next;

        if (s == 0) begin : g_first
            assign x_in[s]    = radicand;
            assign rem_in[s]  = '0;
            assign root_in[s] = '0;
        end else begin : g_rest
            assign x_in[s]    = x_reg[s-1];
            assign rem_in[s]  = rem_reg[s-1];
            assign root_in[s] = root_reg[s-1];
        end

        assign rem_sh    = {rem_in[s][SQ_REM_W-3:0], x_in[s][SQ_IN_W-1 -: 2]};
        assign trial     = {root_in[s], 2'b01};
        assign ge        = rem_sh >= trial;
        assign rem_next  = ge ? rem_sh - trial : rem_sh;
        assign root_next = {root_in[s][SQ_OUT_W-2:0], ge};
        assign x_next    = {x_in[s][SQ_IN_W-3:0], 2'b00};

        always_ff @(posedge aclk) begin
            if (en) begin
                x_reg[s]    <= x_next;
                rem_reg[s]  <= rem_next;
                root_reg[s] <= root_next;
            end
        end
    end

    assign root = root_reg[SQ_OUT_W-1];

endmodule

@@ rtl/line_closest_approach.sv @@
`timescale 1ns / 1ps

// channel   dir  tdata bits                                      tuser
// s_axis    in   dir_a xyz, dir_b xyz (16 each), point_a xyz,   -
//                point_b xyz (20 each), 216 bits
// m_axis    out  signed_distance (21), near_a xyz, near_b xyz    lines_parallel
//                (20 each), 3 zero bits, 144 bits
// cfg       in   cfg_wr_data = parallel_limit (29 bits)          -
//
// one transaction enters per cycle unless the master side stalls; the path is 5 setup
// stages, 41 divider stages (one quotient bit each), 5 stages for step, near points
// and squared distance, 22 square root stages and the output register
// aresetn (synchronous, active low) clears the valid bits and sets the limit to 1
// a stall on the master side holds the whole pipeline in place through one
// common enable; s_axis_tready is high whenever the output register is free
// or being taken
module line_closest_approach (
    input  logic                          aclk,
    input  logic                          aresetn,
    // parallel_limit
    input  logic                          cfg_wr_en,
    input  logic [lca_pkg::LIMIT_W-1:0]   cfg_wr_data,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // dir_a_x, dir_a_y, dir_a_z, dir_b_x, dir_b_y, dir_b_z,
    // point_a_x, point_a_y, point_a_z, point_b_x, point_b_y, point_b_z
    input  logic [215:0]                  s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // signed_distance, near_a_x, near_a_y, near_a_z, near_b_x, near_b_y,
    // near_b_z, zero fill
    output logic [143:0]                  m_axis_tdata,
    // lines_parallel
    output logic                          m_axis_tuser
);
    import lca_pkg::*;

    localparam int PUU_W = 2 * DIR_W;
    localparam int D_W   = POS_W + 1;
    localparam int PDA_W = D_W + DIR_W;
    localparam int DOTS_W = PUU_W + 2;
    localparam int DOT_W = DOT_FRAC + 2;
    localparam int AS_W  = PDA_W + 2;
    localparam int AP_W  = AS_W - PROJ_DROP;
    localparam int SQ_W  = 2 * DOT_W;
    localparam int MA_W  = DOT_W + AP_W;
    localparam int WIDE_W = 62;
    localparam int NUM_W = DIV_N_W + 1;
    localparam int DEN_W = DIV_D_W + 1;
    localparam int PT_W  = STEP_W + DIR_W;
    localparam int SH_W  = PT_W - DIR_FRAC_BITS;
    localparam int NS_W  = SH_W + 1;
    localparam int DSQ_W = 2 * D_W;
    localparam int DIV_LAT = DIV_Q_W;
    localparam int SQ_LAT  = SQ_OUT_W;

    localparam logic signed [DOTS_W-1:0] DOT_ONE  = DOTS_W'(1) <<< DOT_FRAC;
    localparam logic signed [SQ_W-1:0]   DEN_ONE  = SQ_W'(1) <<< (2 * DOT_FRAC);
    localparam logic [STEP_W-1:0]        STEP_MAX = STEP_W'(1) << (DIV_Q_W - 1);
    localparam logic signed [NS_W-1:0]   NEAR_MAX = NS_W'((1 << (POS_W - 1)) - 1);
    localparam logic signed [NS_W-1:0]   NEAR_MIN = -NS_W'(1 << (POS_W - 1));
    localparam logic [SQ_OUT_W-1:0]      DIST_MAX = SQ_OUT_W'((1 << (DIST_W - 1)) - 1);

    logic en;
    logic [LIMIT_W-1:0] limit_reg;
    logic [LIMIT_W-1:0] limit_next;

    // config register
    always_comb begin
        limit_next = limit_reg;
        if (cfg_wr_en) begin
            limit_next = cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_W'(1);
        end else begin
            limit_reg <= limit_next;
        end
    end

    // whole pipeline advances together when the output register can move
    logic m_valid_reg;
    assign en            = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    geom_t g_in;
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            g_in.ua[i] = s_axis_tdata[DIR_W*i +: DIR_W];
            g_in.ub[i] = s_axis_tdata[DIR_W*(3+i) +: DIR_W];
            g_in.pa[i] = s_axis_tdata[6*DIR_W + POS_W*i +: POS_W];
            g_in.pb[i] = s_axis_tdata[6*DIR_W + POS_W*(3+i) +: POS_W];
        end
    end

    // valid bits of the setup stages
    logic [4:0] v_reg;
    logic [4:0] v_next;
    assign v_next = {v_reg[3:0], s_axis_tvalid};

    // stage 1: direction products and point difference projections
    logic signed [PUU_W-1:0] puu_reg [3];
    logic signed [PDA_W-1:0] pda_reg [3];
    logic signed [PDA_W-1:0] pdb_reg [3];
    geom_t g1_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                puu_reg[i] <= $signed(g_in.ua[i]) * $signed(g_in.ub[i]);
                pda_reg[i] <= ($signed({g_in.pa[i][POS_W-1], g_in.pa[i]})
                              - $signed({g_in.pb[i][POS_W-1], g_in.pb[i]}))
                              * $signed(g_in.ua[i]);
                pdb_reg[i] <= ($signed({g_in.pa[i][POS_W-1], g_in.pa[i]})
                              - $signed({g_in.pb[i][POS_W-1], g_in.pb[i]}))
                              * $signed(g_in.ub[i]);
            end
            g1_reg <= g_in;
        end
    end

    // stage 2: sums, dot product clamp, projections dropped by 8 bits
    logic signed [DOTS_W-1:0] dot_sum;
    logic signed [AS_W-1:0]   a_sum;
    logic signed [AS_W-1:0]   b_sum;
    logic signed [DOT_W-1:0]  dot28_next;
    logic signed [DOT_W-1:0]  dot28_reg;
    logic signed [AP_W-1:0]   ap_reg;
    logic signed [AP_W-1:0]   bp_reg;
    geom_t g2_reg;

    always_comb begin
        dot_sum = DOTS_W'(puu_reg[0]) + DOTS_W'(puu_reg[1]) + DOTS_W'(puu_reg[2]);
        a_sum   = AS_W'(pda_reg[0]) + AS_W'(pda_reg[1]) + AS_W'(pda_reg[2]);
        b_sum   = AS_W'(pdb_reg[0]) + AS_W'(pdb_reg[1]) + AS_W'(pdb_reg[2]);
        if (dot_sum > DOT_ONE) begin
            dot28_next = DOT_W'(DOT_ONE);
        end else if (dot_sum < -DOT_ONE) begin
            dot28_next = -DOT_W'(DOT_ONE);
        end else begin
            dot28_next = dot_sum[DOT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dot28_reg <= dot28_next;
            ap_reg    <= a_sum[AS_W-1:PROJ_DROP];
            bp_reg    <= b_sum[AS_W-1:PROJ_DROP];
            g2_reg    <= g1_reg;
        end
    end

    // stage 3: products with the dot product
    logic signed [SQ_W-1:0]  dsq_reg;
    logic signed [MA_W-1:0]  ma_reg;
    logic signed [MA_W-1:0]  mb_reg;
    logic signed [DOT_W-1:0] dot3_reg;
    logic signed [AP_W-1:0]  ap3_reg;
    logic signed [AP_W-1:0]  bp3_reg;
    geom_t g3_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            dsq_reg  <= dot28_reg * dot28_reg;
            ma_reg   <= dot28_reg * ap_reg;
            mb_reg   <= dot28_reg * bp_reg;
            dot3_reg <= dot28_reg;
            ap3_reg  <= ap_reg;
            bp3_reg  <= bp_reg;
            g3_reg   <= g2_reg;
        end
    end

    // stage 4: denominator, parallel test, numerators and divisors
    logic signed [SQ_W-1:0]   den;
    logic signed [SQ_W-1:0]   neg_den;
    logic                     par_next;
    logic signed [DEN_W-1:0]  ds;
    logic signed [WIDE_W-1:0] n1_wide;
    logic signed [WIDE_W-1:0] n2_wide;
    logic signed [NUM_W-1:0]  n1_reg;
    logic signed [NUM_W-1:0]  n2_reg;
    logic signed [DEN_W-1:0]  d1_reg;
    logic signed [DEN_W-1:0]  d2_reg;
    logic                     par4_reg;
    geom_t g4_reg;

    always_comb begin
        den      = dsq_reg - DEN_ONE;
        neg_den  = -den;
        par_next = neg_den < $signed({3'b000, limit_reg, DOT_FRAC'(0)});
        ds       = den[DEN_SHIFT +: DEN_W];
        n2_wide  = WIDE_W'(ma_reg) - (WIDE_W'(bp3_reg) <<< DOT_FRAC);
        if (par_next) begin
            n1_wide = -(WIDE_W'(bp3_reg) <<< DEN_SHIFT);
        end else begin
            n1_wide = (WIDE_W'(ap3_reg) <<< DOT_FRAC) - WIDE_W'(mb_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n1_reg   <= n1_wide[NUM_W-1:0];
            n2_reg   <= n2_wide[NUM_W-1:0];
            d1_reg   <= par_next ? DEN_W'(dot3_reg) : ds;
            d2_reg   <= ds;
            par4_reg <= par_next;
            g4_reg   <= g3_reg;
        end
    end

    // stage 5: magnitudes and sign flags
    logic [DIV_N_W-1:0] nm1_reg;
    logic [DIV_N_W-1:0] nm2_reg;
    logic [DIV_D_W-1:0] dm1_reg;
    logic [DIV_D_W-1:0] dm2_reg;
    div_flag_t f1_reg;
    div_flag_t f2_reg;
    logic      par5_reg;
    geom_t     g5_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            nm1_reg  <= n1_reg[NUM_W-1] ? DIV_N_W'(-n1_reg) : n1_reg[DIV_N_W-1:0];
            nm2_reg  <= n2_reg[NUM_W-1] ? DIV_N_W'(-n2_reg) : n2_reg[DIV_N_W-1:0];
            dm1_reg  <= d1_reg[DEN_W-1] ? DIV_D_W'(-d1_reg) : d1_reg[DIV_D_W-1:0];
            dm2_reg  <= d2_reg[DEN_W-1] ? DIV_D_W'(-d2_reg) : d2_reg[DIV_D_W-1:0];
            f1_reg.neg   <= n1_reg[NUM_W-1] ^ d1_reg[DEN_W-1];
            f1_reg.nneg  <= n1_reg[NUM_W-1];
            f1_reg.nzero <= n1_reg == '0;
            f1_reg.dzero <= d1_reg == '0;
            f1_reg.ovf   <= 1'b0;
            f2_reg.neg   <= n2_reg[NUM_W-1] ^ d2_reg[DEN_W-1];
            f2_reg.nneg  <= n2_reg[NUM_W-1];
            f2_reg.nzero <= n2_reg == '0;
            f2_reg.dzero <= d2_reg == '0;
            f2_reg.ovf   <= 1'b0;
            par5_reg <= par4_reg;
            g5_reg   <= g4_reg;
        end
    end

    // quotient would exceed the 41 bits the divider produces
    div_side_t div_side_in;
    always_comb begin
        div_side_in        = {g5_reg, par5_reg, f1_reg, f2_reg};
        div_side_in.f1.ovf = DIV_CMP_W'(nm1_reg) >= (DIV_CMP_W'(dm1_reg) << DIV_Q_W);
        div_side_in.f2.ovf = DIV_CMP_W'(nm2_reg) >= (DIV_CMP_W'(dm2_reg) << DIV_Q_W);
    end

    logic [DIV_Q_W-1:0] q1;
    logic [DIV_Q_W-1:0] q2;

    lca_div u_div1 (
        .aclk    (aclk),
        .en      (en),
        .num_mag (nm1_reg),
        .den_mag (dm1_reg),
        .quo     (q1)
    );

    lca_div u_div2 (
        .aclk    (aclk),
        .en      (en),
        .num_mag (nm2_reg),
        .den_mag (dm2_reg),
        .quo     (q2)
    );

    // sideband and valid bits alongside the divider stages
    div_side_t          dside_reg [DIV_LAT];
    logic [DIV_LAT-1:0] dv_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            dside_reg[0] <= div_side_in;
            for (int i = 1; i < DIV_LAT; i++) begin
                dside_reg[i] <= dside_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_reg <= '0;
        end else if (en) begin
            dv_reg <= {dv_reg[DIV_LAT-2:0], v_reg[4]};
        end
    end

    div_side_t dside;
    assign dside = dside_reg[DIV_LAT-1];

    // step selection: zero divisor, overflow, clamp
    function automatic logic signed [STEP_W-1:0] step_sel(
        input div_flag_t          f,
        input logic [DIV_Q_W-1:0] q
    );
        logic [STEP_W-1:0] mag;
        logic              sgn;
        if (f.dzero) begin
            mag = f.nzero ? '0 : STEP_MAX;
            sgn = f.nneg;
        end else if (f.ovf || (STEP_W'(q) > STEP_MAX)) begin
            mag = STEP_MAX;
            sgn = f.neg;
        end else begin
            mag = STEP_W'(q);
            sgn = f.neg;
        end
        return sgn ? -$signed(mag) : $signed(mag);
    endfunction

    logic signed [STEP_W-1:0] t1_reg;
    logic signed [STEP_W-1:0] t2_reg;
    logic                     part_reg;
    geom_t                    gt_reg;
    logic                     vt_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            t1_reg   <= step_sel(dside.f1, q1);
            t2_reg   <= dside.par ? '0 : step_sel(dside.f2, q2);
            part_reg <= dside.par;
            gt_reg   <= dside.g;
        end
    end

    // step times direction
    logic signed [PT_W-1:0] pta_reg [3];
    logic signed [PT_W-1:0] ptb_reg [3];
    logic                   parm_reg;
    geom_t                  gm_reg;
    logic                   vm_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                pta_reg[i] <= t1_reg * $signed(gt_reg.ua[i]);
                ptb_reg[i] <= t2_reg * $signed(gt_reg.ub[i]);
            end
            parm_reg <= part_reg;
            gm_reg   <= gt_reg;
        end
    end

    // near points with saturation
    function automatic logic [POS_W-1:0] near_sat(
        input logic [POS_W-1:0]    p,
        input logic signed [PT_W-1:0] pt
    );
        logic signed [NS_W-1:0] s;
        s = NS_W'($signed(p)) + NS_W'($signed(pt[PT_W-1:DIR_FRAC_BITS]));
        if (s > NEAR_MAX) begin
            s = NEAR_MAX;
        end else if (s < NEAR_MIN) begin
            s = NEAR_MIN;
        end
        return s[POS_W-1:0];
    endfunction

    sq_side_t nside_reg;
    logic     vn_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                nside_reg.na[i] <= near_sat(gm_reg.pa[i], pta_reg[i]);
                nside_reg.nb[i] <= near_sat(gm_reg.pb[i], ptb_reg[i]);
            end
            nside_reg.par <= parm_reg;
            nside_reg.pos <= $signed(gm_reg.pb[2]) > $signed(gm_reg.pa[2]);
        end
    end

    // squared coordinate differences
    logic signed [D_W-1:0] ndiff [3];
    logic [DSQ_W-1:0] dsq3_reg [3];
    sq_side_t         qside_reg;
    logic             vq_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            ndiff[i] = $signed({nside_reg.na[i][POS_W-1], nside_reg.na[i]})
                     - $signed({nside_reg.nb[i][POS_W-1], nside_reg.nb[i]});
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                dsq3_reg[i] <= DSQ_W'(ndiff[i]) * DSQ_W'(ndiff[i]);
            end
            qside_reg <= nside_reg;
        end
    end

    // radicand
    logic [SQ_IN_W-1:0] rad_reg;
    sq_side_t           rside_reg;
    logic               vr_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            rad_reg   <= SQ_IN_W'(dsq3_reg[0]) + SQ_IN_W'(dsq3_reg[1])
                       + SQ_IN_W'(dsq3_reg[2]);
            rside_reg <= qside_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg  <= '0;
            vt_reg <= 1'b0;
            vm_reg <= 1'b0;
            vn_reg <= 1'b0;
            vq_reg <= 1'b0;
            vr_reg <= 1'b0;
        end else if (en) begin
            v_reg  <= v_next;
            vt_reg <= dv_reg[DIV_LAT-1];
            vm_reg <= vt_reg;
            vn_reg <= vm_reg;
            vq_reg <= vn_reg;
            vr_reg <= vq_reg;
        end
    end

    logic [SQ_OUT_W-1:0] root;

    lca_sqrt u_sqrt (
        .aclk     (aclk),
        .en       (en),
        .radicand (rad_reg),
        .root     (root)
    );

    // sideband and valid bits alongside the root stages
    sq_side_t          sside_reg [SQ_LAT];
    logic [SQ_LAT-1:0] sv_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            sside_reg[0] <= rside_reg;
            for (int i = 1; i < SQ_LAT; i++) begin
                sside_reg[i] <= sside_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sv_reg <= '0;
        end else if (en) begin
            sv_reg <= {sv_reg[SQ_LAT-2:0], vr_reg};
        end
    end

    // output register: clamp, sign, pack
    sq_side_t            oside;
    logic [SQ_OUT_W-1:0] dist_c;
    logic [DIST_W-1:0]   dist_s;
    logic [143:0]        m_data_reg;
    logic                m_user_reg;

    assign oside  = sside_reg[SQ_LAT-1];
    assign dist_c = (root > DIST_MAX) ? DIST_MAX : root;
    assign dist_s = oside.pos ? dist_c[DIST_W-1:0] : DIST_W'(-dist_c);

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= {3'b000, oside.nb[2], oside.nb[1], oside.nb[0],
                           oside.na[2], oside.na[1], oside.na[0], dist_s};
            m_user_reg <= oside.par;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= sv_reg[SQ_LAT-1];
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

endmodule

@@ tb/tb_line_closest_approach.sv @@
`timescale 1ns / 1ps

module tb_line_closest_approach;
    import lca_pkg::*;

    typedef struct {
        logic signed [DIR_W-1:0] ua [3];
        logic signed [DIR_W-1:0] ub [3];
        logic signed [POS_W-1:0] pa [3];
        logic signed [POS_W-1:0] pb [3];
    } line_pair_t;

    typedef struct {
        logic signed [DIST_W-1:0] sep;
        logic signed [POS_W-1:0]  na [3];
        logic signed [POS_W-1:0]  nb [3];
        logic                     par;
    } approach_t;

    typedef struct {
        line_pair_t g;
        bit         typed;
        approach_t  r;
    } stim_row_t;

    localparam longint STEP_LIM = longint'(1) << 40;
    localparam longint ONE_Q28  = longint'(1) << DOT_FRAC;
    localparam int     DRAIN    = 100;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [LIMIT_W-1:0]   cfg_wr_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [215:0]         s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [143:0]         m_axis_tdata;
    logic                 m_axis_tuser;

    approach_t    pending_results [$];
    logic [LIMIT_W-1:0] par_limit = LIMIT_W'(1);
    bit           no_idle = 1'b0;
    int           n_fail = 0;
    int           n_sent = 0;
    int           n_recv = 0;
    int           n_par = 0;
    int           n_limits = 1;

    line_closest_approach uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // truncating divide with saturation, zero divisor goes to the rail unless the numerator is zero
    function automatic longint step_quot(input longint num, input longint dvs);
        longint q;
        if (dvs == 0)
            return num > 0 ? STEP_LIM : (num < 0 ? -STEP_LIM : 0);
        q = num / dvs;
        if (q > STEP_LIM) q = STEP_LIM;
        if (q < -STEP_LIM) q = -STEP_LIM;
        return q;
    endfunction

    function automatic longint isqrt(input longint unsigned x);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return longint'(res);
    endfunction

    function automatic longint sat_pos(input longint v);
        if (v > 524287) return 524287;
        if (v < -524288) return -524288;
        return v;
    endfunction

    // nearest points on both lines and their signed separation
    function automatic approach_t closest_points(input line_pair_t g,
                                                 input logic [LIMIT_W-1:0] lim);
        approach_t r;
        longint dot, pa_proj, pb_proj, d, dot28, ap, bp, den, ds, t1, t2, mag, df;
        longint na_v [3];
        longint nb_v [3];
        longint unsigned sum;
        dot = 0;
        pa_proj = 0;
        pb_proj = 0;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            d = longint'(g.pa[i]) - longint'(g.pb[i]);
            dot += longint'(g.ua[i]) * longint'(g.ub[i]);
            pa_proj += d * longint'(g.ua[i]);
            pb_proj += d * longint'(g.ub[i]);
        end
        // Q2.28 already when directions are Q1.14
        dot28 = dot >>> (2 * DIR_FRAC_BITS - DOT_FRAC);
        if (dot28 > ONE_Q28) dot28 = ONE_Q28;
        if (dot28 < -ONE_Q28) dot28 = -ONE_Q28;
        ap = pa_proj >>> PROJ_DROP;
        bp = pb_proj >>> PROJ_DROP;
        den = dot28 * dot28 - (longint'(1) << (2 * DOT_FRAC));
        r.par = (-den) < (longint'(lim) << DOT_FRAC);
        if (r.par) begin
            t1 = step_quot(-bp * (longint'(1) << DEN_SHIFT), dot28);
            t2 = 0;
        end else begin
            ds = den >>> DEN_SHIFT;
            t1 = step_quot(ap * ONE_Q28 - dot28 * bp, ds);
            t2 = step_quot(dot28 * ap - bp * ONE_Q28, ds);
        end
        for (int i = 0; i < 3; i++) begin
            na_v[i] = sat_pos(longint'(g.pa[i]) + ((t1 * longint'(g.ua[i])) >>> DIR_FRAC_BITS));
            nb_v[i] = sat_pos(longint'(g.pb[i]) + ((t2 * longint'(g.ub[i])) >>> DIR_FRAC_BITS));
            df = na_v[i] - nb_v[i];
            sum += longint'(df * df);
            r.na[i] = na_v[i][POS_W-1:0];
            r.nb[i] = nb_v[i][POS_W-1:0];
        end
        mag = isqrt(sum);
        if (mag > 1048575) mag = 1048575;
        // sign follows z of line b versus z of line a
        if (g.pb[2] > g.pa[2]) r.sep = mag[DIST_W-1:0];
        else r.sep = DIST_W'(-mag);
        return r;
    endfunction

    function automatic logic [215:0] pack_pair(input line_pair_t g);
        return {g.pb[2], g.pb[1], g.pb[0], g.pa[2], g.pa[1], g.pa[0],
                g.ub[2], g.ub[1], g.ub[0], g.ua[2], g.ua[1], g.ua[0]};
    endfunction

    function automatic line_pair_t make_pair(input int ax, ay, az, bx, by, bz,
                                             input int px, py, pz, qx, qy, qz);
        line_pair_t g;
        g.ua[0] = DIR_W'(ax); g.ua[1] = DIR_W'(ay); g.ua[2] = DIR_W'(az);
        g.ub[0] = DIR_W'(bx); g.ub[1] = DIR_W'(by); g.ub[2] = DIR_W'(bz);
        g.pa[0] = POS_W'(px); g.pa[1] = POS_W'(py); g.pa[2] = POS_W'(pz);
        g.pb[0] = POS_W'(qx); g.pb[1] = POS_W'(qy); g.pb[2] = POS_W'(qz);
        return g;
    endfunction

    // all-zero result, used where the outcome is obvious
    function automatic approach_t zero_result(input logic par);
        approach_t r;
        r.sep = '0;
        r.par = par;
        for (int i = 0; i < 3; i++) begin
            r.na[i] = '0;
            r.nb[i] = '0;
        end
        return r;
    endfunction

    // random unit vector in Q1.14
    function automatic void unit_dir(output int v [3]);
        real c [3];
        real n;
        n = 0.0;
        for (int i = 0; i < 3; i++) begin
            c[i] = real'($urandom_range(0, 2000)) - 1000.0;
            n += c[i] * c[i];
        end
        if (n < 1.0) begin
            c[0] = 1.0;
            n = 1.0;
        end
        n = $sqrt(n);
        for (int i = 0; i < 3; i++) begin
            v[i] = $rtoi(c[i] / n * 16384.0);
            if (v[i] > 16384) v[i] = 16384;
            if (v[i] < -16384) v[i] = -16384;
        end
    endfunction

    function automatic int clip_dir(input int v);
        return v > 16384 ? 16384 : (v < -16384 ? -16384 : v);
    endfunction

    function automatic line_pair_t random_pair();
        line_pair_t g;
        int a [3];
        int b [3];
        int kind;
        int sgn;
        kind = $urandom_range(0, 99);
        unit_dir(a);
        unit_dir(b);
        sgn = $urandom_range(0, 1) ? 1 : -1;
        for (int i = 0; i < 3; i++) begin
            if (kind >= 45 && kind < 70)
                b[i] = clip_dir(sgn * a[i] + $urandom_range(0, 6) - 3);
            else if (kind >= 70 && kind < 80)
                b[i] = sgn * a[i];
            else if (kind >= 80) begin
                a[i] = $urandom_range(0, 32768) - 16384;
                b[i] = $urandom_range(0, 32768) - 16384;
            end
            g.ua[i] = DIR_W'(a[i]);
            g.ub[i] = DIR_W'(b[i]);
            if ($urandom_range(0, 4) == 0) begin
                g.pa[i] = POS_W'($urandom);
                g.pb[i] = POS_W'($urandom);
            end else begin
                g.pa[i] = POS_W'($urandom_range(0, 131072) - 65536);
                g.pb[i] = POS_W'($urandom_range(0, 131072) - 65536);
            end
        end
        return g;
    endfunction

    // one transaction on the slave side, expectation queued on acceptance
    task automatic send_pair(input line_pair_t g, input bit typed, input approach_t r);
        int gap;
        approach_t exp_r;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= pack_pair(g);
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        exp_r = typed ? r : closest_points(g, par_limit);
        pending_results.insert(pending_results.size(), exp_r);
        n_sent++;
        @(negedge aclk);
    endtask

    // register writes only with the pipeline empty
    task automatic write_limit(input logic [LIMIT_W-1:0] v);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (DRAIN) @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        par_limit = v;
        n_limits++;
    endtask

    task automatic run_random(input int count);
        for (int i = 0; i < count; i++) begin
            if (i % 60 == 0) no_idle = ($urandom_range(0, 3) == 0);
            if (i == count / 2) begin
                // hold off until the pipeline has drained
                s_axis_tvalid <= 1'b0;
                while (pending_results.size() != 0) @(negedge aclk);
            end
            send_pair(random_pair(), 1'b0, zero_result(1'b0));
        end
    endtask

    // master side: random stall before each transaction
    initial begin
        int stall;
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 7);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_axis_tready <= 1'b1;
            @(posedge aclk);
            while (!m_axis_tvalid) @(posedge aclk);
            @(negedge aclk);
        end
    end

    // result checker, compares against the oldest expectation
    always @(posedge aclk) begin
        approach_t want;
        logic signed [POS_W-1:0] got_a;
        logic signed [POS_W-1:0] got_b;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            n_recv++;
            if (pending_results.size() == 0) begin
                $error("result with nothing expected: %h", m_axis_tdata);
                n_fail++;
            end else begin
                want = pending_results.pop_front();
                if (want.par) n_par++;
                if (m_axis_tdata[20:0] !== want.sep) begin
                    $error("signed_distance expected %0d got %0d", want.sep,
                           $signed(m_axis_tdata[20:0]));
                    n_fail++;
                end
                for (int i = 0; i < 3; i++) begin
                    got_a = m_axis_tdata[21 + 20*i +: 20];
                    got_b = m_axis_tdata[81 + 20*i +: 20];
                    if (got_a !== want.na[i]) begin
                        $error("near_a[%0d] expected %0d got %0d", i, want.na[i], got_a);
                        n_fail++;
                    end
                    if (got_b !== want.nb[i]) begin
                        $error("near_b[%0d] expected %0d got %0d", i, want.nb[i], got_b);
                        n_fail++;
                    end
                end
                if (m_axis_tdata[143:141] !== 3'b000) begin
                    $error("zero fill expected 0 got %b", m_axis_tdata[143:141]);
                    n_fail++;
                end
                if (m_axis_tuser !== want.par) begin
                    $error("lines_parallel expected %0b got %0b", want.par, m_axis_tuser);
                    n_fail++;
                end
            end
        end
    end

    initial begin
        stim_row_t rows [$];
        stim_row_t row;
        logic [LIMIT_W-1:0] mid_limit;

        // directed rows, a few with the result typed in
        row.typed = 1'b1;
        row.g = make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        row.r = zero_result(1'b0);
        rows.insert(rows.size(), row);
        row.g = make_pair(16384, 0, 0, 16384, 0, 0, 0, 0, 0, 0, 0, 0);
        row.r = zero_result(1'b1);
        rows.insert(rows.size(), row);
        row.g = make_pair(0, 0, -16384, 0, 0, 16384, 0, 0, 0, 0, 0, 0);
        row.r = zero_result(1'b1);
        rows.insert(rows.size(), row);
        row.typed = 1'b0;
        row.r = zero_result(1'b0);
        // crossing axes, skew axes with z above and below
        row.g = make_pair(16384, 0, 0, 0, 16384, 0, 0, 0, 0, 0, 0, 0);
        rows.insert(rows.size(), row);
        row.g = make_pair(16384, 0, 0, 0, 16384, 0, 256, 0, 0, 0, 0, 512);
        rows.insert(rows.size(), row);
        row.g = make_pair(16384, 0, 0, 0, 16384, 0, 0, 0, 512, 0, 0, 0);
        rows.insert(rows.size(), row);
        row.g = make_pair(0, 16384, 0, 16384, 0, 0, 9, 9, 300, 9, 9, 300);
        rows.insert(rows.size(), row);
        // parallel offset and antiparallel
        row.g = make_pair(16384, 0, 0, 16384, 0, 0, 100, 0, 0, -900, 700, 50);
        rows.insert(rows.size(), row);
        row.g = make_pair(0, 16384, 0, 0, -16384, 0, 0, 5000, 0, 0, -5000, -77);
        rows.insert(rows.size(), row);
        // near parallel, tiny divisor
        row.g = make_pair(16384, 0, 0, 16383, 180, 0, 0, 0, 0, 0, 4000, 9);
        rows.insert(rows.size(), row);
        // extremes of every field, non-unit directions that clamp the dot product
        row.g = make_pair(16384, 16384, 16384, 16384, 16384, 16384,
                          524287, 524287, 524287, -524288, -524288, -524288);
        rows.insert(rows.size(), row);
        row.g = make_pair(-16384, -16384, -16384, 16384, 16384, 16384,
                          -524288, -524288, -524288, 524287, 524287, 524287);
        rows.insert(rows.size(), row);
        row.g = make_pair(-16384, 16384, -16384, 16384, -16384, -1,
                          524287, -524288, 1, -524288, 524287, -1);
        rows.insert(rows.size(), row);
        row.g = make_pair(16384, 0, 1, 0, 1, 16384,
                          524287, -524288, 0, -524288, 524287, 0);
        rows.insert(rows.size(), row);
        row.g = make_pair(3, -5, 7, -2, 9, 1, 1000, -3000, 77, 2, 4, 6);
        rows.insert(rows.size(), row);
        row.g = make_pair(16384, 0, 0, 16384, 0, 0,
                          524287, 524287, 0, -524288, -524288, 0);
        rows.insert(rows.size(), row);

        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (rows[i]) send_pair(rows[i].g, rows[i].typed, rows[i].r);
        run_random(360);

        // limit of zero: exactly parallel lines give a zero divisor
        write_limit('0);
        foreach (rows[i]) send_pair(rows[i].g, 1'b0, rows[i].r);
        run_random(360);

        write_limit(29'd268435456);
        run_random(360);

        mid_limit = LIMIT_W'($urandom_range(2, 268435455));
        write_limit(mid_limit);
        run_random(360);

        write_limit(29'd1);
        run_random(360);

        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (DRAIN) @(negedge aclk);

        $display("covered %0d line pairs over %0d limit settings, %0d results, %0d parallel",
                 n_sent, n_limits, n_recv, n_par);
        if (n_fail == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches", n_fail);
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("status: fail");
        $finish;
    end

endmodule
